// ===== design/greedy_min_distance_pair_matcher_core_assert.svh =====
// Assertion helpers used by the matcher engine (gmdpm_back).
`ifndef GREEDY_MIN_DISTANCE_PAIR_MATCHER_CORE_ASSERT_SVH
`define GREEDY_MIN_DISTANCE_PAIR_MATCHER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define GMDPM_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("gmdpm assertion failed");
// Condition must never be seen at a clock edge outside reset.
`define GMDPM_ASSERT_NEVER(name, clk, rstn, cond) \
  name: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("gmdpm forbidden condition seen");
`else
`define GMDPM_ASSERT(name, clk, rstn, prop)
`define GMDPM_ASSERT_NEVER(name, clk, rstn, cond)
`endif

`endif

// ===== design/gmdpm_pkg.sv =====
package gmdpm_pkg;

  localparam int MAX_ROWS     = 16;
  localparam int MAX_COLS     = 16;
  localparam int RESULT_LIMIT = 16;

  localparam int IDX_W  = 4;
  localparam int DIST_W = 24;
  localparam int CUT_W  = DIST_W + 1;
  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int ADDR_W = ROW_W + COL_W;
  localparam int RCNT_W = $clog2(MAX_ROWS + 1);
  localparam int CCNT_W = $clog2(MAX_COLS + 1);
  localparam int PASS_W = $clog2(RESULT_LIMIT + 1);

  localparam logic [DIST_W-1:0] FLOOR_RESET  = DIST_W'(6554);
  localparam logic [DIST_W-1:0] CUTOFF_RESET = DIST_W'(9830);

  // Configuration register indexes.
  localparam logic REG_FLOOR_THRESHOLD = 1'b0;
  localparam logic REG_INITIAL_CUTOFF  = 1'b1;

  typedef struct packed {
    logic [IDX_W-1:0]  row_index;
    logic [IDX_W-1:0]  col_index;
    logic [DIST_W-1:0] distance_value;
    logic              last_element;
  } in_item_t;

  typedef struct packed {
    logic              found;
    logic [IDX_W-1:0]  match_row;
    logic [IDX_W-1:0]  match_col;
    logic [DIST_W-1:0] match_distance;
    logic              last_result;
  } res_item_t;

  // Classified load command from the front end to the engine.
  typedef struct packed {
    logic              store;
    logic [ADDR_W-1:0] addr;
    logic [DIST_W-1:0] data;
    logic              start;
    logic [RCNT_W-1:0] rows;
    logic [CCNT_W-1:0] cols;
  } cmd_t;

  typedef struct packed {
    logic [DIST_W-1:0] floor_threshold;
    logic [DIST_W-1:0] initial_cutoff;
  } cfg_t;

endpackage

// ===== design/gmdpm_front.sv =====
module gmdpm_front import gmdpm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  in_item_t in_item_i,
  output logic     full_o,
  output logic     cmd_valid_o,
  output cmd_t     cmd_o,
  input  logic     cmd_pop_i
);

  cmd_t       q_mem [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;
  cmd_t       cmd_new;
  logic [RCNT_W-1:0] row_p1;
  logic [CCNT_W-1:0] col_p1;

  // Classify the element: bounds check, store address and run size.
  always_comb begin
    row_p1 = RCNT_W'(in_item_i.row_index) + RCNT_W'(1);
    col_p1 = CCNT_W'(in_item_i.col_index) + CCNT_W'(1);
    cmd_new.store = (RCNT_W'(in_item_i.row_index) < RCNT_W'(MAX_ROWS)) &&
                    (CCNT_W'(in_item_i.col_index) < CCNT_W'(MAX_COLS));
    cmd_new.addr  = {ROW_W'(in_item_i.row_index), COL_W'(in_item_i.col_index)};
    cmd_new.data  = in_item_i.distance_value;
    cmd_new.start = in_item_i.last_element;
    cmd_new.rows  = (row_p1 > RCNT_W'(MAX_ROWS)) ? RCNT_W'(MAX_ROWS) : row_p1;
    cmd_new.cols  = (col_p1 > CCNT_W'(MAX_COLS)) ? CCNT_W'(MAX_COLS) : col_p1;
  end

  assign full_o      = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_mem[rptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = cmd_pop_i && cmd_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      q_mem[wptr_q] <= cmd_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (do_push) begin
        wptr_q <= ~wptr_q;
      end
      if (do_pop) begin
        rptr_q <= ~rptr_q;
      end
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

// ===== design/gmdpm_resq.sv =====
module gmdpm_resq import gmdpm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      res_push_i,
  input  res_item_t res_item_i,
  output logic      res_full_o,
  output logic      empty_o,
  output res_item_t res_item_o,
  input  logic      pop_i
);

  res_item_t  q_mem [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign res_full_o = (cnt_q == 2'd2);
  assign empty_o    = (cnt_q == 2'd0);
  assign res_item_o = q_mem[rptr_q];
  assign do_push    = res_push_i && !res_full_o;
  assign do_pop     = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      q_mem[wptr_q] <= res_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (do_push) begin
        wptr_q <= ~wptr_q;
      end
      if (do_pop) begin
        rptr_q <= ~rptr_q;
      end
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

// ===== design/gmdpm_back.sv =====
`include "greedy_min_distance_pair_matcher_core_assert.svh"

module gmdpm_back import gmdpm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      cmd_valid_i,
  input  cmd_t      cmd_i,
  output logic      cmd_pop_o,
  output logic      res_push_o,
  output res_item_t res_item_o,
  input  logic      res_full_i
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MAX    = 3'd1;
  localparam logic [2:0] S_MIN    = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_WROW   = 3'd4;
  localparam logic [2:0] S_WCOL   = 3'd5;
  localparam logic [2:0] S_FINISH = 3'd6;

  logic [DIST_W-1:0] mem [2**ADDR_W];

  logic [2:0]        state_q, state_d;
  logic [RCNT_W-1:0] rows_q, rows_d;
  logic [CCNT_W-1:0] cols_q, cols_d;
  logic [PASS_W-1:0] passes_q, passes_d, pass_q, pass_d;
  logic [ROW_W-1:0]  sr_q, sr_d, br_q, br_d, rd_r_q;
  logic [COL_W-1:0]  sc_q, sc_d, bc_q, bc_d, rd_c_q;
  logic              issue_q, issue_d, rd_v_q, rd_last_q, have_q, have_d;
  logic [DIST_W-1:0] rd_data_q, max_q, max_d, best_q, best_d;
  logic [CUT_W-1:0]  cutoff_q, cutoff_d;
  res_item_t         pend_q, pend_d;
  logic              pend_v_q, pend_v_d;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [DIST_W-1:0] mem_wdata;
  logic              cmd_pop, res_push, scan_last, row_end, col_end, abort_run;
  res_item_t         res_item;
  logic [RCNT_W-1:0] min_rc;

  assign row_end   = (RCNT_W'(sr_q) + RCNT_W'(1)) == rows_q;
  assign col_end   = (CCNT_W'(sc_q) + CCNT_W'(1)) == cols_q;
  assign scan_last = row_end && col_end;
  assign abort_run = (best_q > cfg_i.floor_threshold) && ({1'b0, best_q} > cutoff_q);
  assign min_rc    = (RCNT_W'(cmd_i.cols) < cmd_i.rows) ? RCNT_W'(cmd_i.cols) : cmd_i.rows;

  always_comb begin
    state_d   = state_q;
    rows_d    = rows_q;
    cols_d    = cols_q;
    passes_d  = passes_q;
    pass_d    = pass_q;
    sr_d      = sr_q;
    sc_d      = sc_q;
    br_d      = br_q;
    bc_d      = bc_q;
    issue_d   = issue_q;
    have_d    = have_q;
    max_d     = max_q;
    best_d    = best_q;
    cutoff_d  = cutoff_q;
    pend_d    = pend_q;
    pend_v_d  = pend_v_q;
    mem_we    = 1'b0;
    mem_waddr = {sr_q, sc_q};
    mem_wdata = max_q;
    cmd_pop   = 1'b0;
    res_push  = 1'b0;
    res_item  = pend_q;

    // Column-major scan address generator, one read a cycle.
    if (issue_q) begin
      if (scan_last) begin
        issue_d = 1'b0;
      end else if (row_end) begin
        sr_d = '0;
        sc_d = sc_q + COL_W'(1);
      end else begin
        sr_d = sr_q + ROW_W'(1);
      end
    end

    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop   = 1'b1;
          mem_we    = cmd_i.store;
          mem_waddr = cmd_i.addr;
          mem_wdata = cmd_i.data;
          if (cmd_i.start) begin
            rows_d   = cmd_i.rows;
            cols_d   = cmd_i.cols;
            passes_d = (min_rc > RCNT_W'(RESULT_LIMIT)) ? PASS_W'(RESULT_LIMIT)
                                                        : PASS_W'(min_rc);
            pass_d   = '0;
            max_d    = '0;
            cutoff_d = {1'b0, cfg_i.initial_cutoff};
            pend_v_d = 1'b0;
            sr_d     = '0;
            sc_d     = '0;
            issue_d  = 1'b1;
            state_d  = S_MAX;
          end
        end
      end
      S_MAX: begin
        if (rd_v_q && (rd_data_q > max_q)) begin
          max_d = rd_data_q;
        end
        if (rd_last_q) begin
          sr_d    = '0;
          sc_d    = '0;
          issue_d = 1'b1;
          have_d  = 1'b0;
          state_d = S_MIN;
        end
      end
      S_MIN: begin
        if (rd_v_q && (!have_q || (rd_data_q < best_q))) begin
          best_d = rd_data_q;
          br_d   = rd_r_q;
          bc_d   = rd_c_q;
          have_d = 1'b1;
        end
        if (rd_last_q) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (abort_run) begin
          if (pend_v_q) begin
            state_d = S_FINISH;
          end else if (!res_full_i) begin
            res_push = 1'b1;
            res_item = '{found: 1'b0, match_row: '0, match_col: '0,
                         match_distance: '0, last_result: 1'b1};
            state_d  = S_IDLE;
          end
        end else if (!pend_v_q || !res_full_i) begin
          res_push = pend_v_q;
          pend_d   = '{found: 1'b1, match_row: IDX_W'(br_q), match_col: IDX_W'(bc_q),
                       match_distance: best_q, last_result: 1'b0};
          pend_v_d = 1'b1;
          cutoff_d = {best_q, 1'b0};
          pass_d   = pass_q + PASS_W'(1);
          sc_d     = '0;
          state_d  = S_WROW;
        end
      end
      S_WROW: begin
        mem_we    = 1'b1;
        mem_waddr = {br_q, sc_q};
        if (col_end) begin
          sr_d    = '0;
          state_d = S_WCOL;
        end else begin
          sc_d = sc_q + COL_W'(1);
        end
      end
      S_WCOL: begin
        mem_we    = 1'b1;
        mem_waddr = {sr_q, bc_q};
        if (!row_end) begin
          sr_d = sr_q + ROW_W'(1);
        end else if (pass_q == passes_q) begin
          state_d = S_FINISH;
        end else begin
          sr_d    = '0;
          sc_d    = '0;
          issue_d = 1'b1;
          have_d  = 1'b0;
          state_d = S_MIN;
        end
      end
      S_FINISH: begin
        if (!res_full_i) begin
          res_push             = 1'b1;
          res_item.last_result = 1'b1;
          pend_v_d             = 1'b0;
          state_d              = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign cmd_pop_o  = cmd_pop;
  assign res_push_o = res_push;
  assign res_item_o = res_item;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem[{sr_q, sc_q}];
  end

  always_ff @(posedge clk_i) begin
    rd_r_q <= sr_q;
    rd_c_q <= sc_q;
    rows_q <= rows_d;
    cols_q <= cols_d;
    br_q   <= br_d;
    bc_q   <= bc_d;
    max_q  <= max_d;
    best_q <= best_d;
    pend_q <= pend_d;
    cutoff_q <= cutoff_d;
    passes_q <= passes_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      pass_q    <= '0;
      sr_q      <= '0;
      sc_q      <= '0;
      issue_q   <= 1'b0;
      rd_v_q    <= 1'b0;
      rd_last_q <= 1'b0;
      have_q    <= 1'b0;
      pend_v_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      pass_q    <= pass_d;
      sr_q      <= sr_d;
      sc_q      <= sc_d;
      issue_q   <= issue_d;
      rd_v_q    <= issue_q;
      rd_last_q <= issue_q && scan_last;
      have_q    <= have_d;
      pend_v_q  <= pend_v_d;
    end
  end

  `GMDPM_ASSERT(a_pop_only_idle, clk_i, rst_ni, cmd_pop |-> (state_q == S_IDLE))
  `GMDPM_ASSERT_NEVER(a_push_when_full, clk_i, rst_ni, res_push && res_full_i)
  `GMDPM_ASSERT(a_pass_bound, clk_i, rst_ni, (state_q == S_IDLE) || (pass_q <= passes_q))
  `GMDPM_ASSERT(a_no_write_in_scan, clk_i, rst_ni, mem_we |-> (!rd_v_q && !issue_q))

endmodule

// ===== design/greedy_min_distance_pair_matcher_core.sv =====
// Greedy minimum-distance pair matcher. Elements of a distance matrix (unsigned
// Q8.16) are pushed one request at a time; the element flagged last_element sets
// the matrix size and starts a matching run, which returns one result request per
// matched pair (the final one flagged last_result) or a single not-found result.
// A load element is written to the store as the engine takes it. A run of R rows
// and C columns first scans all R*C entries for the maximum, then for each pass
// scans them again for the minimum, makes a decision, and overwrites the chosen
// row and column, and finally closes the run; the pace is set by the single
// read port of the 256-entry distance store, read once per cycle. A two-entry
// queue sits in front of the engine and another behind it, so loads keep
// arriving while a run is busy and results wait without holding up the engine
// until a queue fills.
// Configuration (floor threshold, initial cutoff) must be written while idle.
module greedy_min_distance_pair_matcher_core import gmdpm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  input  in_item_t          in_item_i,
  output logic              full,
  output logic              empty,
  output res_item_t         res_item_o,
  input  logic              pop,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [DIST_W-1:0] cfg_wdata_i
);

  cfg_t      cfg_q;
  logic      cmd_valid, cmd_pop, res_push, res_full;
  cmd_t      cmd;
  res_item_t res_item;

  // Configuration registers: plain writes, no read-back.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.floor_threshold <= FLOOR_RESET;
      cfg_q.initial_cutoff  <= CUTOFF_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FLOOR_THRESHOLD: cfg_q.floor_threshold <= cfg_wdata_i;
        REG_INITIAL_CUTOFF:  cfg_q.initial_cutoff  <= cfg_wdata_i;
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  // The front end classifies each element into a load command and queues it.
  gmdpm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .in_item_i   (in_item_i),
    .full_o      (full),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  // The engine owns the distance store and runs the greedy passes.
  gmdpm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_push_o  (res_push),
    .res_item_o  (res_item),
    .res_full_i  (res_full)
  );

  // Results wait here until the consumer pops them.
  gmdpm_resq u_resq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_push_i (res_push),
    .res_item_i (res_item),
    .res_full_o (res_full),
    .empty_o    (empty),
    .res_item_o (res_item_o),
    .pop_i      (pop)
  );

endmodule
